// ----- hw/rtl/msx_pkg.sv -----
package msx_pkg;

  localparam int PC_W    = 10;
  localparam int TABLE_W = 52;
  localparam int INST_W  = 40;
  localparam int CYC_W   = 48;
  localparam int MIDX_W  = 16;
  localparam int ADDR_W  = 12;

  localparam logic [TABLE_W-1:0] TABLE_RESET = 52'h1111111111111;
  localparam logic [4:0]         SP_INDEX    = 5'd29;
  localparam logic [31:0]        SP_RESET    = 32'd4096;
  localparam logic [4:0]         LINK_INDEX  = 5'd31;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_SLL     = 4'd2,
    OP_SRL     = 4'd3,
    OP_JR      = 4'd4,
    OP_LW      = 4'd5,
    OP_SW      = 4'd6,
    OP_J       = 4'd7,
    OP_JAL     = 4'd8,
    OP_BEQ     = 4'd9,
    OP_BNE     = 4'd10,
    OP_BLEZ    = 4'd11,
    OP_BGTZ    = 4'd12,
    OP_PRELOAD = 4'd13
  } op_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic [4:0]         dest_reg;
    logic [4:0]         source_reg;
    logic [4:0]         second_reg;
    logic [4:0]         shift_amount;
    logic signed [15:0] offset;
    logic [PC_W-1:0]    jump_target;
    logic [ADDR_W-1:0]  preload_address;
    logic signed [31:0] preload_value;
  } in_item_t;

  typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic               reg_written;
    logic [4:0]         written_reg;
    logic signed [31:0] written_value;
    logic               mem_written;
    logic [ADDR_W-1:0]  mem_address;
    logic signed [31:0] mem_value;
    logic               address_error;
    logic [INST_W-1:0]  instruction_total;
    logic [CYC_W-1:0]   cycle_total;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [MIDX_W-1:0] idx;
    logic [31:0]       wdata;
  } dmem_req_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

  typedef struct packed {
    out_item_t item;
    logic      is_load;
    dmem_req_t mem;
  } ex_res_t;

  function automatic logic [31:0] reg_reset_val(input logic [4:0] idx);
    return (idx == SP_INDEX) ? SP_RESET : 32'd0;
  endfunction

endpackage

// ----- hw/rtl/msx_regfile.sv -----
module msx_regfile (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rd_en,
  input  logic [4:0]     ra0,
  input  logic [4:0]     ra1,
  input  msx_pkg::rf_wr_t wr,
  output logic [31:0]    rd0,
  output logic [31:0]    rd1
);
  import msx_pkg::*;

  logic [31:0] mem [32];
  logic [31:0] valid_r;
  logic [31:0] rd0_r;
  logic [31:0] rd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // write-first: a read at the same edge as a write to that entry sees the new word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.addr == ra0) begin
        rd0_r <= wr.data;
      end else if (valid_r[ra0]) begin
        rd0_r <= mem[ra0];
      end else begin
        rd0_r <= reg_reset_val(ra0);
      end
      if (wr.en && wr.addr == ra1) begin
        rd1_r <= wr.data;
      end else if (valid_r[ra1]) begin
        rd1_r <= mem[ra1];
      end else begin
        rd1_r <= reg_reset_val(ra1);
      end
    end
  end

  assign rd0 = rd0_r;
  assign rd1 = rd1_r;

endmodule

// ----- hw/rtl/msx_dmem.sv -----
module msx_dmem #(
  parameter int DATA_WORDS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  msx_pkg::dmem_req_t req,
  output logic [31:0]        rd_data,
  output logic               clr_busy
);
  import msx_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);

  logic [31:0]   mem [DATA_WORDS];
  logic [31:0]   rd_data_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_idx_r;

  // sweep zeros through every word after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == AW'(DATA_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.en && req.we) begin
      mem[req.idx[AW-1:0]] <= req.wdata;
    end
    if (req.en && !req.we) begin
      rd_data_r <= mem[req.idx[AW-1:0]];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// ----- hw/rtl/msx_exec.sv -----
module msx_exec #(
  parameter int DATA_WORDS = 4096
) (
  input  msx_pkg::in_item_t              item,
  input  logic [31:0]                    rs_v,
  input  logic [31:0]                    rt_v,
  input  logic [msx_pkg::PC_W-1:0]       pc,
  input  logic [msx_pkg::INST_W-1:0]     inst,
  input  logic [msx_pkg::CYC_W-1:0]      cyc,
  input  logic [msx_pkg::TABLE_W-1:0]    cost_table,
  output msx_pkg::ex_res_t               res
);
  import msx_pkg::*;

  logic [PC_W-1:0]   seq;
  logic [PC_W-1:0]   br_tgt;
  logic [PC_W-1:0]   npc;
  logic [32:0]       addr;
  logic              addr_bad;
  logic              wreg;
  logic [4:0]        widx;
  logic [31:0]       wval;
  logic              wmem;
  logic [31:0]       mval;
  logic              mrd;
  logic              aerr;
  logic              addr_ok;
  logic              counted;
  logic [63:0]       tbl64;
  logic [3:0]        cost;
  logic [CYC_W:0]    cyc_sum;
  logic [INST_W-1:0] inst_nxt;
  logic [CYC_W-1:0]  cyc_nxt;

  assign seq    = pc + 1'b1;
  assign br_tgt = seq + item.offset[PC_W-1:0];

  // preload uses its own index; lw/sw use base plus sign-extended displacement
  always_comb begin
    if (item.mode == OP_PRELOAD) begin
      addr = {{(33 - ADDR_W){1'b0}}, item.preload_address};
    end else begin
      addr = {rs_v[31], rs_v} + {{17{item.offset[15]}}, item.offset};
    end
    addr_bad = addr[32] || (addr[31:0] >= 32'(DATA_WORDS));
  end

  always_comb begin
    npc     = seq;
    wreg    = 1'b0;
    widx    = item.dest_reg;
    wval    = '0;
    wmem    = 1'b0;
    mval    = '0;
    mrd     = 1'b0;
    aerr    = 1'b0;
    addr_ok = 1'b0;
    case (op_t'(item.mode))
      OP_ADD: begin
        wreg = 1'b1;
        wval = rs_v + rt_v;
      end
      OP_SUB: begin
        wreg = 1'b1;
        wval = rs_v - rt_v;
      end
      OP_SLL: begin
        wreg = 1'b1;
        wval = rt_v << item.shift_amount;
      end
      OP_SRL: begin
        wreg = 1'b1;
        wval = rt_v >> item.shift_amount;
      end
      OP_JR: begin
        npc = rs_v[PC_W-1:0];
      end
      OP_LW: begin
        aerr    = addr_bad;
        addr_ok = !addr_bad;
        mrd     = !addr_bad;
        wreg    = !addr_bad;
        widx    = item.second_reg;
      end
      OP_SW: begin
        aerr    = addr_bad;
        addr_ok = !addr_bad;
        wmem    = !addr_bad;
        mval    = rt_v;
      end
      OP_J: begin
        npc = item.jump_target;
      end
      OP_JAL: begin
        wreg = 1'b1;
        widx = LINK_INDEX;
        wval = {{(32 - PC_W){1'b0}}, seq};
        npc  = item.jump_target;
      end
      OP_BEQ: begin
        if (rs_v == rt_v) npc = br_tgt;
      end
      OP_BNE: begin
        if (rs_v != rt_v) npc = br_tgt;
      end
      OP_BLEZ: begin
        if (rs_v[31] || rs_v == '0) npc = br_tgt;
      end
      OP_BGTZ: begin
        if (!rs_v[31] && rs_v != '0) npc = br_tgt;
      end
      OP_PRELOAD: begin
        npc     = pc;
        aerr    = addr_bad;
        addr_ok = !addr_bad;
        wmem    = !addr_bad;
        mval    = item.preload_value;
      end
      default: begin
      end
    endcase
    // drop writes to register zero
    if (widx == '0) begin
      wreg = 1'b0;
    end
    if (!wreg) begin
      widx = '0;
      wval = '0;
    end
    if (!wmem) begin
      mval = '0;
    end
  end

  assign counted = item.mode < OP_PRELOAD;
  assign tbl64   = {{(64 - TABLE_W){1'b0}}, cost_table};
  assign cost    = counted ? tbl64[{item.mode, 2'b00} +: 4] : 4'd0;
  assign cyc_sum = {1'b0, cyc} + (CYC_W + 1)'(cost);

  always_comb begin
    inst_nxt = inst;
    if (counted && inst != '1) begin
      inst_nxt = inst + 1'b1;
    end
    cyc_nxt = cyc_sum[CYC_W] ? '1 : cyc_sum[CYC_W-1:0];
  end

  always_comb begin
    res.item.next_pc           = npc;
    res.item.reg_written       = wreg;
    res.item.written_reg       = widx;
    res.item.written_value     = wval;
    res.item.mem_written       = wmem;
    res.item.mem_address       = addr_ok ? addr[ADDR_W-1:0] : '0;
    res.item.mem_value         = mval;
    res.item.address_error     = aerr;
    res.item.instruction_total = inst_nxt;
    res.item.cycle_total       = cyc_nxt;
    res.is_load                = mrd && wreg;
    res.mem.en                 = mrd || wmem;
    res.mem.we                 = wmem;
    res.mem.idx                = addr[MIDX_W-1:0];
    res.mem.wdata              = mval;
  end

endmodule

// ----- hw/rtl/mips_subset_execute_unit_top.sv -----
// Execution unit for a small integer instruction subset plus a data preload command.
// Input channel in_valid/in_ready/in_data carries one decoded instruction per transaction;
// the result channel out_valid/out_ready/out_data returns exactly one result per input,
// in order: next pc, register and memory write, address error flag and running totals.
// cfg_we/cfg_wdata load the 52-bit table of per-opcode cycle costs; write it only while idle.
// Pipeline: the register file is read at the accepting edge, the execute stage then computes and
// issues the data memory access, and the write-back stage takes load data and writes the
// register file while loading the output register. Throughput is one transaction per cycle
// while out_ready stays high; results of the write-back stage are forwarded to the execute
// stage, so dependent instructions do not wait.
// Reset: register file back to zero with register 29 at 4096, pc and totals to zero, table
// to one cycle per opcode. The data memory is then swept to zero, one word a cycle, through
// all DATA_WORDS words; in_ready stays low during the sweep.
// When out_ready is low a valid result in the output register holds; the pipeline keeps
// taking transactions until the execute and write-back stages are full, then in_ready drops.
module mips_subset_execute_unit_top #(
  parameter int DATA_WORDS = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  msx_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output msx_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [msx_pkg::TABLE_W-1:0]  cfg_wdata
);
  import msx_pkg::*;

  logic [TABLE_W-1:0] table_r;
  logic [PC_W-1:0]    pc_r,   pc_nxt;
  logic [INST_W-1:0]  inst_r, inst_nxt;
  logic [CYC_W-1:0]   cyc_r,  cyc_nxt;

  logic      ex_v_r;
  in_item_t  ex_item_r;
  logic      wb_v_r;
  out_item_t wb_item_r;
  logic      wb_load_r;
  logic      out_v_r;
  out_item_t out_item_r;

  logic        in_acc;
  logic        ex_go;
  logic        wb_free;
  logic        out_en;
  logic        clr_busy;
  logic [31:0] rf_rd0, rf_rd1;
  logic [31:0] rs_v, rt_v;
  logic [31:0] wb_wval;
  logic [31:0] dmem_rdata;
  out_item_t   wb_out;
  rf_wr_t      rf_wr;
  dmem_req_t   dmem_req;
  ex_res_t     ex_res;

  assign out_en   = wb_v_r && (!out_v_r || out_ready);
  assign wb_free  = !wb_v_r || out_en;
  assign ex_go    = ex_v_r && wb_free;
  assign in_ready = rst_n && !clr_busy && (!ex_v_r || ex_go);
  assign in_acc   = in_valid && in_ready;

  assign wb_wval = wb_load_r ? dmem_rdata : wb_item_r.written_value;

  always_comb begin
    wb_out               = wb_item_r;
    wb_out.written_value = wb_wval;
  end

  assign rf_wr.en   = out_en && wb_item_r.reg_written;
  assign rf_wr.addr = wb_item_r.written_reg;
  assign rf_wr.data = wb_wval;

  msx_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_acc),
    .ra0   (in_data.source_reg),
    .ra1   (in_data.second_reg),
    .wr    (rf_wr),
    .rd0   (rf_rd0),
    .rd1   (rf_rd1)
  );

  // forward the write-back stage's pending register write into execute
  always_comb begin
    rs_v = rf_rd0;
    rt_v = rf_rd1;
    if (wb_v_r && wb_item_r.reg_written && wb_item_r.written_reg == ex_item_r.source_reg) begin
      rs_v = wb_wval;
    end
    if (wb_v_r && wb_item_r.reg_written && wb_item_r.written_reg == ex_item_r.second_reg) begin
      rt_v = wb_wval;
    end
  end

  msx_exec #(
    .DATA_WORDS (DATA_WORDS)
  ) u_exec (
    .item       (ex_item_r),
    .rs_v       (rs_v),
    .rt_v       (rt_v),
    .pc         (pc_r),
    .inst       (inst_r),
    .cyc        (cyc_r),
    .cost_table (table_r),
    .res        (ex_res)
  );

  always_comb begin
    dmem_req    = ex_res.mem;
    dmem_req.en = ex_res.mem.en && ex_go;
  end

  msx_dmem #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dmem_req),
    .rd_data  (dmem_rdata),
    .clr_busy (clr_busy)
  );

  always_comb begin
    pc_nxt   = pc_r;
    inst_nxt = inst_r;
    cyc_nxt  = cyc_r;
    if (ex_go) begin
      pc_nxt   = ex_res.item.next_pc;
      inst_nxt = ex_res.item.instruction_total;
      cyc_nxt  = ex_res.item.cycle_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_r <= TABLE_RESET;
      pc_r    <= '0;
      inst_r  <= '0;
      cyc_r   <= '0;
      ex_v_r  <= 1'b0;
      wb_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_r <= cfg_wdata;
      end
      pc_r   <= pc_nxt;
      inst_r <= inst_nxt;
      cyc_r  <= cyc_nxt;
      if (in_acc) begin
        ex_v_r <= 1'b1;
      end else if (ex_go) begin
        ex_v_r <= 1'b0;
      end
      if (ex_go) begin
        wb_v_r <= 1'b1;
      end else if (out_en) begin
        wb_v_r <= 1'b0;
      end
      if (out_en) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ex_item_r <= in_data;
    end
    if (ex_go) begin
      wb_item_r <= ex_res.item;
      wb_load_r <= ex_res.is_load;
    end
    if (out_en) begin
      out_item_r <= wb_out;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

endmodule

// ----- hw/rtl/msx_checker.sv -----
module msx_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input msx_pkg::out_item_t out_data
);
  import msx_pkg::*;

  logic [INST_W-1:0] last_inst_r;
  logic [CYC_W-1:0]  last_cyc_r;

  // track totals of the last delivered transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_inst_r <= '0;
      last_cyc_r  <= '0;
    end else if (out_valid && out_ready) begin
      last_inst_r <= out_data.instruction_total;
      last_cyc_r  <= out_data.cycle_total;
    end
  end

  a_out_hold: assert property (@(posedge clk)
    rst_n && out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_clear_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("input taken or result shown right after reset");

  a_totals_monotonic: assert property (@(posedge clk)
    rst_n && out_valid |->
      out_data.instruction_total >= last_inst_r && out_data.cycle_total >= last_cyc_r)
    else $error("running totals went backwards");

  a_no_write_fields: assert property (@(posedge clk)
    out_valid && !out_data.reg_written |->
      out_data.written_reg == '0 && out_data.written_value == '0)
    else $error("register write fields set without a write");

  a_err_suppresses: assert property (@(posedge clk)
    out_valid && out_data.address_error |->
      !out_data.mem_written && out_data.mem_address == '0)
    else $error("access not suppressed on address error");

endmodule

bind mips_subset_execute_unit_top msx_checker u_msx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- bench/msx_scoreboard_pkg.sv -----
`timescale 1ns / 100ps

package msx_scoreboard_pkg;
  import msx_pkg::*;

  localparam int MEM_WORDS = 4096;
  localparam logic [INST_W-1:0] INST_CEIL = '1;
  localparam logic [CYC_W-1:0] CYCLE_CEIL = '1;

  class exec_scoreboard;
    logic [31:0] reg_file [32];
    logic [31:0] data_mem [MEM_WORDS];
    logic [PC_W-1:0] pc;
    logic [INST_W-1:0] inst_cnt;
    logic [CYC_W-1:0] cyc_cnt;
    logic [TABLE_W-1:0] cost_table;
    out_item_t expected_q [$];
    int errors;
    int checked;

    function new();
      foreach (reg_file[i]) reg_file[i] = '0;
      reg_file[SP_INDEX] = SP_RESET;
      foreach (data_mem[i]) data_mem[i] = '0;
      pc = '0;
      inst_cnt = '0;
      cyc_cnt = '0;
      cost_table = TABLE_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] reg_value(logic [4:0] idx);
      return (idx == 5'd0) ? 32'd0 : reg_file[idx];
    endfunction

    function void set_table(logic [TABLE_W-1:0] tbl);
      cost_table = tbl;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Execute one accepted instruction against the shadow state and queue its result.
    function void note_input(in_item_t it);
      out_item_t e;
      logic [31:0] rs_v;
      logic [31:0] rt_v;
      logic [PC_W-1:0] seq;
      logic [PC_W-1:0] br;
      logic [PC_W-1:0] npc;
      longint addr;
      logic [3:0] cost;
      logic [CYC_W-1:0] room;
      e = '0;
      rs_v = reg_value(it.source_reg);
      rt_v = reg_value(it.second_reg);
      seq = pc + 1'b1;
      // branch target modulo program size: low bits of pc + 1 + offset
      br = seq + it.offset[PC_W-1:0];
      npc = seq;
      case (it.mode)
        OP_ADD: begin
          e.reg_written = 1'b1;
          e.written_reg = it.dest_reg;
          e.written_value = rs_v + rt_v;
        end
        OP_SUB: begin
          e.reg_written = 1'b1;
          e.written_reg = it.dest_reg;
          e.written_value = rs_v - rt_v;
        end
        OP_SLL: begin
          e.reg_written = 1'b1;
          e.written_reg = it.dest_reg;
          e.written_value = rt_v << it.shift_amount;
        end
        OP_SRL: begin
          e.reg_written = 1'b1;
          e.written_reg = it.dest_reg;
          e.written_value = rt_v >> it.shift_amount;
        end
        OP_JR: npc = rs_v[PC_W-1:0];
        OP_LW, OP_SW: begin
          addr = longint'($signed(rs_v)) + longint'($signed(it.offset));
          if (addr < 0 || addr >= MEM_WORDS) begin
            e.address_error = 1'b1;
          end else begin
            e.mem_address = addr[ADDR_W-1:0];
            if (it.mode == OP_LW) begin
              e.reg_written = 1'b1;
              e.written_reg = it.second_reg;
              e.written_value = data_mem[int'(addr)];
            end else begin
              e.mem_written = 1'b1;
              e.mem_value = rt_v;
            end
          end
        end
        OP_J: npc = it.jump_target;
        OP_JAL: begin
          e.reg_written = 1'b1;
          e.written_reg = LINK_INDEX;
          e.written_value = 32'(seq);
          npc = it.jump_target;
        end
        OP_BEQ: if (rs_v == rt_v) npc = br;
        OP_BNE: if (rs_v != rt_v) npc = br;
        OP_BLEZ: if ($signed(rs_v) <= 0) npc = br;
        OP_BGTZ: if ($signed(rs_v) > 0) npc = br;
        OP_PRELOAD: begin
          npc = pc;
          if (it.preload_address >= MEM_WORDS) begin
            e.address_error = 1'b1;
          end else begin
            e.mem_written = 1'b1;
            e.mem_address = it.preload_address;
            e.mem_value = it.preload_value;
          end
        end
        default: ;
      endcase

      // drop writes to register zero
      if (e.reg_written && e.written_reg == 5'd0) begin
        e.reg_written = 1'b0;
        e.written_value = '0;
      end
      if (e.reg_written) reg_file[e.written_reg] = e.written_value;
      if (e.mem_written) data_mem[e.mem_address] = e.mem_value;

      if (it.mode <= OP_BGTZ) begin
        cost = cost_table[4*it.mode +: 4];
        if (inst_cnt != INST_CEIL) inst_cnt = inst_cnt + 1'b1;
        room = CYCLE_CEIL - cyc_cnt;
        cyc_cnt = (room < cost) ? CYCLE_CEIL : cyc_cnt + cost;
      end
      pc = npc;

      e.next_pc = npc;
      e.instruction_total = inst_cnt;
      e.cycle_total = cyc_cnt;
      expected_q = {expected_q, e};
    endfunction

    function void cmp(string field, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, field, exp_v, got_v);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      cmp("next_pc", e.next_pc, got.next_pc);
      cmp("reg_written", e.reg_written, got.reg_written);
      cmp("written_reg", e.written_reg, got.written_reg);
      cmp("written_value", $unsigned(e.written_value), $unsigned(got.written_value));
      cmp("mem_written", e.mem_written, got.mem_written);
      cmp("mem_address", e.mem_address, got.mem_address);
      cmp("mem_value", $unsigned(e.mem_value), $unsigned(got.mem_value));
      cmp("address_error", e.address_error, got.address_error);
      cmp("instruction_total", e.instruction_total, got.instruction_total);
      cmp("cycle_total", e.cycle_total, got.cycle_total);
    endfunction
  endclass

endpackage

// ----- bench/tb_mips_subset_execute_unit_top.sv -----
`timescale 1ns / 100ps

module tb_mips_subset_execute_unit_top;
  import msx_pkg::*;
  import msx_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 245;
  localparam logic [3:0] MODE_SPARE_LO = 4'd14;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;
  localparam logic [TABLE_W-1:0] TABLE_ZERO = '0;
  localparam logic [TABLE_W-1:0] TABLE_FULL = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [TABLE_W-1:0] cfg_wdata;

  exec_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_count = 0;
  int cycle_count = 0;

  mips_subset_execute_unit_top #(.DATA_WORDS(MEM_WORDS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: sample at the rising edge, pick the stall for the next cycle at the falling one.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid && out_ready) sb.check_result(out_data);
      @(negedge clk);
      out_ready = (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_item_t instr(logic [3:0] mode, logic [4:0] rd, logic [4:0] rs,
                                     logic [4:0] rt, logic [4:0] sh, logic [15:0] off,
                                     logic [PC_W-1:0] tgt = '0, logic [ADDR_W-1:0] paddr = '0,
                                     logic [31:0] pval = '0);
    in_item_t it;
    it = '0;
    it.mode = mode;
    it.dest_reg = rd;
    it.source_reg = rs;
    it.second_reg = rt;
    it.shift_amount = sh;
    it.offset = off;
    it.jump_target = tgt;
    it.preload_address = paddr;
    it.preload_value = pval;
    return it;
  endfunction

  // Favor a few registers so results feed straight into the next instructions.
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(3) != 0) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    return ($urandom_range(3) != 0) ? ADDR_W'($urandom_range(63))
                                    : ADDR_W'($urandom_range(MEM_WORDS - 1));
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [95:0] bits;
    int pick;
    longint gap;
    bits = {$urandom(), $urandom(), $urandom()};
    it = bits[93:0];
    it.dest_reg = pick_reg();
    it.source_reg = pick_reg();
    it.second_reg = pick_reg();
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.mode = OP_PRELOAD;
      it.preload_address = pick_addr();
      // small words become usable base addresses once loaded
      if ($urandom_range(1)) it.preload_value = $urandom_range(MEM_WORDS + 63);
    end else if (pick < 36) begin
      it.mode = $urandom_range(1) ? OP_LW : OP_SW;
      if ($urandom_range(4) != 0) begin
        gap = longint'(pick_addr()) - longint'($signed(sb.reg_value(it.source_reg)));
        if (gap < -32768 || gap > 32767) begin
          it.source_reg = 5'd0;
          gap = longint'(pick_addr());
        end
        it.offset = gap[15:0];
      end
    end else if (pick < 66) begin
      it.mode = 4'($urandom_range(OP_SRL, OP_ADD));
    end else if (pick < 86) begin
      it.mode = 4'($urandom_range(OP_BGTZ, OP_BEQ));
      if ($urandom_range(3) == 0) it.second_reg = it.source_reg;
      if ($urandom_range(1)) it.offset = 16'(int'($urandom_range(16)) - 8);
    end else if (pick < 97) begin
      case ($urandom_range(2))
        0: it.mode = OP_JR;
        1: it.mode = OP_J;
        default: it.mode = OP_JAL;
      endcase
    end else begin
      it.mode = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
    end
    return it;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance with valid still high.
  task automatic send_item(input in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    sent_count++;
    @(negedge clk);
  endtask

  // Hold the sender until every queued transaction has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cost_table(input logic [TABLE_W-1:0] tbl);
    cfg_we = 1'b1;
    cfg_wdata = tbl;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_table(tbl);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [TABLE_W-1:0] tbl, input int count);
    drain_results();
    write_cost_table(tbl);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_item(rand_item());
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset table, no idling
    send_item(instr(OP_ADD, 1, SP_INDEX, 0, 0, 0));
    send_item(instr(OP_PRELOAD, 0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff));
    send_item(instr(OP_PRELOAD, 0, 0, 0, 0, 0, 0, 12'hfff, 32'h8000_0000));
    send_item(instr(OP_LW, 0, 0, 2, 0, 0));
    send_item(instr(OP_LW, 0, 0, 3, 0, 4095));
    send_item(instr(OP_ADD, 4, 2, 2, 0, 0));
    send_item(instr(OP_SUB, 5, 3, 2, 0, 0));
    send_item(instr(OP_SLL, 6, 0, 3, 1, 0));
    send_item(instr(OP_SLL, 7, 0, 2, 31, 0));
    send_item(instr(OP_SRL, 8, 0, 3, 31, 0));
    send_item(instr(OP_ADD, 0, 2, 3, 0, 0));
    send_item(instr(OP_LW, 0, 0, 10, 0, -1));
    send_item(instr(OP_SW, 0, SP_INDEX, 2, 0, 0));
    send_item(instr(OP_SW, 0, SP_INDEX, 3, 0, -1));
    send_item(instr(OP_LW, 0, SP_INDEX, 11, 0, -4096));
    send_item(instr(OP_LW, 0, 0, 12, 0, 32767));
    send_item(instr(OP_SW, 0, SP_INDEX, 2, 0, -32768));
    send_item(instr(OP_J, 0, 0, 0, 0, 0, 1023));
    send_item(instr(OP_JAL, 0, 0, 0, 0, 0, 0));
    send_item(instr(OP_BEQ, 0, 0, 0, 0, -32768));
    send_item(instr(OP_BNE, 0, 2, 3, 0, 32767));
    send_item(instr(OP_BLEZ, 0, 3, 0, 0, 5));
    send_item(instr(OP_BGTZ, 0, 2, 0, 0, -3));
    send_item(instr(OP_BGTZ, 0, 3, 0, 0, 7));
    send_item(instr(OP_JR, 0, 2, 0, 0, 0));
    send_item(instr(MODE_SPARE_LO, 0, 0, 0, 0, 0));
    send_item(instr(MODE_SPARE_HI, 0, 0, 0, 0, 0));

    run_phase(0, 0, {$urandom(), $urandom()}, PHASE_ITEMS);
    run_phase(60, 0, TABLE_FULL, PHASE_ITEMS);
    run_phase(0, 60, TABLE_ZERO, PHASE_ITEMS);
    run_phase(38, 38, {$urandom(), $urandom()}, PHASE_ITEMS);
    run_phase(38, 38, TABLE_RESET, PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_results();
    $display("summary: %0d instructions sent (directed, then five idling and cost-table phases)",
             sent_count);
    $display("summary: %0d results checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
